[hw/rtl/assert_macros.svh]
// assertion helpers for the checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, held off during reset
`define HS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, held off during reset
`define HS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[hw/rtl/hs_pkg.sv]
package hs_pkg;

  typedef logic [31:0] word_t;
  typedef logic [7:0][31:0] cv_t;

  localparam int KEY_WORDS = 4;
  localparam int CFG_IDX_W = 2;
  localparam int BLK_WORDS = 16;
  localparam int BLK_AW = 4;

  localparam logic [7:0] INNER_PAD = 8'h36;
  localparam logic [7:0] OUTER_PAD = 8'h5c;
  localparam logic [63:0] KEY_BLOCK_BYTES = 64'd64;
  localparam word_t PAD_MARK_WORD = 32'h8000_0000;
  // outer message is key block plus 32-byte digest, in bits
  localparam word_t OUTER_BITS = 32'd768;

  localparam cv_t HASH_IV = {
    32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
    32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
  };

  typedef struct packed {
    logic  load;
    word_t wdata;
    logic  start;
  } comp_ctl_t;

  function automatic word_t rotr(input word_t x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic word_t round_k(input logic [5:0] idx);
    word_t k;
    case (idx)
      6'd0: k = 32'h428a2f98;  6'd1: k = 32'h71374491;
      6'd2: k = 32'hb5c0fbcf;  6'd3: k = 32'he9b5dba5;
      6'd4: k = 32'h3956c25b;  6'd5: k = 32'h59f111f1;
      6'd6: k = 32'h923f82a4;  6'd7: k = 32'hab1c5ed5;
      6'd8: k = 32'hd807aa98;  6'd9: k = 32'h12835b01;
      6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe;
      6'd14: k = 32'h9bdc06a7; 6'd15: k = 32'hc19bf174;
      6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc;
      6'd20: k = 32'h2de92c6f; 6'd21: k = 32'h4a7484aa;
      6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d;
      6'd26: k = 32'hb00327c8; 6'd27: k = 32'hbf597fc7;
      6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967;
      6'd32: k = 32'h27b70a85; 6'd33: k = 32'h2e1b2138;
      6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb;
      6'd38: k = 32'h81c2c92e; 6'd39: k = 32'h92722c85;
      6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3;
      6'd44: k = 32'hd192e819; 6'd45: k = 32'hd6990624;
      6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08;
      6'd50: k = 32'h2748774c; 6'd51: k = 32'h34b0bcb5;
      6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3;
      6'd56: k = 32'h748f82ee; 6'd57: k = 32'h78a5636f;
      6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb;
      6'd62: k = 32'hbef9a3f7; 6'd63: k = 32'hc67178f2;
      default: k = 32'h0;
    endcase
    return k;
  endfunction

endpackage

[hw/rtl/hs_ram.sv]
module hs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[hw/rtl/hs_compress.sv]
module hs_compress import hs_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  comp_ctl_t ctl,
  input  cv_t       cv_in,
  output logic      done,
  output cv_t       vars
);

  logic              run_r;
  logic              done_r;
  logic [5:0]        rnd_r;
  cv_t               vars_r;
  logic [15:0][31:0] w_r;

  word_t a, b, c, d, e, f, g, h;
  word_t t1, t2, s0, s1, sched, w_new;

  always_comb begin
    a = vars_r[0]; b = vars_r[1]; c = vars_r[2]; d = vars_r[3];
    e = vars_r[4]; f = vars_r[5]; g = vars_r[6]; h = vars_r[7];
    t1 = h + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g))
         + round_k(rnd_r) + w_r[0];
    t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
    // next schedule word, w[t+16] from the sliding window
    s0 = rotr(w_r[1], 7) ^ rotr(w_r[1], 18) ^ (w_r[1] >> 3);
    s1 = rotr(w_r[14], 17) ^ rotr(w_r[14], 19) ^ (w_r[14] >> 10);
    sched = w_r[0] + s0 + w_r[9] + s1;
    w_new = ctl.load ? ctl.wdata : sched;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      rnd_r  <= 6'd0;
    end else begin
      done_r <= run_r && (rnd_r == 6'd63);
      if (ctl.start) begin
        vars_r <= cv_in;
        rnd_r  <= 6'd0;
        run_r  <= 1'b1;
      end else if (run_r) begin
        vars_r <= {g, f, e, d + t1, c, b, a, t1 + t2};
        rnd_r  <= rnd_r + 6'd1;
        if (rnd_r == 6'd63) begin
          run_r <= 1'b0;
        end
      end
    end
    if (ctl.load || run_r) begin
      w_r <= {w_new, w_r[15:1]};
    end
  end

  assign done = done_r;
  assign vars = vars_r;

endmodule

[hw/rtl/hmac_sha256_engine.sv]
// sequence: the first beat of a message first fills and hashes the inner key block; a beat
// then absorbs its bytes one at a time and compresses each 64-byte block it completes
// last beat adds padding and length writes, a possible spill block, then three
// more compressions with two 16-word fills
// flow: one beat at a time; in_stall stays high until the engine is back in idle
// reset: synchronous active-low rst_n clears key, chain and control; buffer ram is not cleared
module hmac_sha256_engine import hs_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [63:0]          in_data_word,
  input  logic [3:0]           in_byte_count,
  input  logic                 in_last,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [63:0]          out_mac_word_0,
  output logic [63:0]          out_mac_word_1,
  output logic [63:0]          out_mac_word_2,
  output logic [63:0]          out_mac_word_3,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [63:0]          cfg_data
);

  typedef enum logic [3:0] {
    S_IDLE, S_ABSORB, S_KFILL, S_FFILL, S_LOAD, S_GO, S_WAIT, S_PAD, S_LEN, S_OUT
  } state_t;

  // where to continue once a compression finishes
  typedef enum logic [2:0] {
    R_ABSORB, R_PAD, R_INNER, R_OKEY, R_FINISH
  } ret_t;

  state_t state_r;
  ret_t   ret_r;

  logic [KEY_WORDS-1:0][63:0] key_r;
  logic [63:0] data_r;
  logic [3:0]  cnt_r;
  logic [3:0]  k_r;
  logic        last_r;
  logic        phase_r;       // 0: key block pending, 1: absorbing
  logic [63:0] len_r;
  logic [5:0]  pp_r;          // byte position while padding
  logic        pad_first_r;
  word_t       cur_r;         // partially assembled buffer word
  logic [63:0] bits_r;
  logic [3:0]  wi_r;
  logic        outer_r;
  logic [4:0]  ld_r;
  logic        rd_pend_r;
  cv_t         cv_r;
  cv_t         dig_r;
  logic        out_valid_r;
  logic [3:0][63:0] mac_r;

  logic          ram_we;
  logic [BLK_AW-1:0] ram_waddr, ram_raddr;
  word_t         ram_wdata, ram_rdata;
  comp_ctl_t     cctl;
  logic          c_done;
  cv_t           c_vars;
  cv_t           cv_sum;
  word_t         cur_abs, cur_pad, key_blk_word, fin_word;
  logic [7:0]    pad_byte, fill;
  logic [3:0]    cnt_sat;
  logic          pad_stop;

  function automatic word_t put_byte(input word_t w, input logic [7:0] bv,
                                     input logic [1:0] lane);
    word_t r;
    r = w;
    case (lane)
      2'd0: r[31:24] = bv;
      2'd1: r[23:16] = bv;
      2'd2: r[15:8]  = bv;
      2'd3: r[7:0]   = bv;
      default: r = w;
    endcase
    return r;
  endfunction

  hs_ram #(.WIDTH(32), .DEPTH(BLK_WORDS)) u_buf (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  hs_compress u_comp (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (cctl),
    .cv_in (cv_r),
    .done  (c_done),
    .vars  (c_vars)
  );

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      cv_sum[i] = cv_r[i] + c_vars[i];
    end
    fill = outer_r ? OUTER_PAD : INNER_PAD;
    // zero-padded key block, key bytes only in the first eight words
    if (!wi_r[3]) begin
      key_blk_word = (wi_r[0] ? key_r[wi_r[2:1]][31:0] : key_r[wi_r[2:1]][63:32])
                     ^ {4{fill}};
    end else begin
      key_blk_word = {4{fill}};
    end
    // outer message block: inner digest, pad mark, zeros, bit length
    if (!wi_r[3]) begin
      fin_word = dig_r[wi_r[2:0]];
    end else if (wi_r == 4'd8) begin
      fin_word = PAD_MARK_WORD;
    end else if (wi_r == 4'd15) begin
      fin_word = OUTER_BITS;
    end else begin
      fin_word = '0;
    end
    cur_abs  = put_byte(cur_r, data_r[63:56], len_r[1:0]);
    pad_byte = pad_first_r ? 8'h80 : 8'h00;
    cur_pad  = put_byte(cur_r, pad_byte, pp_r[1:0]);
    pad_stop = !pad_first_r && (pp_r == 6'd56);
    cnt_sat  = (in_byte_count > 4'd8) ? 4'd8 : in_byte_count;

    ram_we    = 1'b0;
    ram_waddr = wi_r;
    ram_wdata = key_blk_word;
    case (state_r)
      S_KFILL: begin
        ram_we = 1'b1;
      end
      S_FFILL: begin
        ram_we    = 1'b1;
        ram_wdata = fin_word;
      end
      S_ABSORB: begin
        ram_we    = (k_r != cnt_r) && (len_r[1:0] == 2'd3);
        ram_waddr = len_r[5:2];
        ram_wdata = cur_abs;
      end
      S_PAD: begin
        ram_we    = !pad_stop && (pp_r[1:0] == 2'd3);
        ram_waddr = pp_r[5:2];
        ram_wdata = cur_pad;
      end
      S_LEN: begin
        ram_we    = 1'b1;
        ram_waddr = {3'b111, wi_r[0]};
        ram_wdata = wi_r[0] ? bits_r[31:0] : bits_r[63:32];
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
    ram_raddr   = ld_r[3:0];
    cctl.load   = rd_pend_r;
    cctl.wdata  = ram_rdata;
    cctl.start  = (state_r == S_GO);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ret_r       <= R_ABSORB;
      key_r       <= '0;
      phase_r     <= 1'b0;
      len_r       <= '0;
      cv_r        <= HASH_IV;
      out_valid_r <= 1'b0;
      rd_pend_r   <= 1'b0;
      ld_r        <= '0;
      k_r         <= '0;
      wi_r        <= '0;
      pad_first_r <= 1'b0;
      outer_r     <= 1'b0;
    end else begin
      if (cfg_valid) begin
        key_r[cfg_index] <= cfg_data;
      end
      // S_OUT reloads the output register itself
      if (out_valid_r && !out_stall && (state_r != S_OUT)) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            data_r <= in_data_word;
            cnt_r  <= cnt_sat;
            last_r <= in_last;
            k_r    <= '0;
            if (!phase_r) begin
              // first beat of a message: hash the inner key block first
              phase_r <= 1'b1;
              len_r   <= '0;
              wi_r    <= '0;
              cv_r    <= HASH_IV;
              outer_r <= 1'b0;
              ret_r   <= R_ABSORB;
              state_r <= S_KFILL;
            end else begin
              state_r <= S_ABSORB;
            end
          end
        end
        S_KFILL, S_FFILL: begin
          wi_r <= wi_r + 4'd1;
          if (wi_r == 4'd15) begin
            ld_r    <= '0;
            state_r <= S_LOAD;
          end
        end
        S_ABSORB: begin
          if (k_r == cnt_r) begin
            if (last_r) begin
              bits_r      <= (len_r + KEY_BLOCK_BYTES) << 3;
              pp_r        <= len_r[5:0];
              pad_first_r <= 1'b1;
              state_r     <= S_PAD;
            end else begin
              state_r <= S_IDLE;
            end
          end else begin
            cur_r  <= cur_abs;
            data_r <= data_r << 8;
            k_r    <= k_r + 4'd1;
            len_r  <= len_r + 64'd1;
            if (len_r[5:0] == 6'd63) begin
              ret_r   <= R_ABSORB;
              ld_r    <= '0;
              state_r <= S_LOAD;
            end
          end
        end
        S_PAD: begin
          if (pad_stop) begin
            wi_r    <= '0;
            state_r <= S_LEN;
          end else begin
            cur_r       <= cur_pad;
            pad_first_r <= 1'b0;
            pp_r        <= pp_r + 6'd1;
            if (pp_r == 6'd63) begin
              ret_r   <= R_PAD;
              ld_r    <= '0;
              state_r <= S_LOAD;
            end
          end
        end
        S_LEN: begin
          wi_r <= wi_r + 4'd1;
          if (wi_r[0]) begin
            ret_r   <= R_INNER;
            ld_r    <= '0;
            state_r <= S_LOAD;
          end
        end
        S_LOAD: begin
          // read issued here; the registered ram word is shifted into the schedule while rd_pend_r is set
          if (ld_r[4]) begin
            rd_pend_r <= 1'b0;
            state_r   <= S_GO;
          end else begin
            rd_pend_r <= 1'b1;
            ld_r      <= ld_r + 5'd1;
          end
        end
        S_GO: begin
          state_r <= S_WAIT;
        end
        S_WAIT: begin
          if (c_done) begin
            case (ret_r)
              R_ABSORB: begin
                cv_r    <= cv_sum;
                state_r <= S_ABSORB;
              end
              R_PAD: begin
                cv_r    <= cv_sum;
                state_r <= S_PAD;
              end
              R_INNER: begin
                dig_r   <= cv_sum;
                cv_r    <= HASH_IV;
                outer_r <= 1'b1;
                wi_r    <= '0;
                ret_r   <= R_OKEY;
                state_r <= S_KFILL;
              end
              R_OKEY: begin
                cv_r    <= cv_sum;
                wi_r    <= '0;
                ret_r   <= R_FINISH;
                state_r <= S_FFILL;
              end
              R_FINISH: begin
                cv_r    <= cv_sum;
                state_r <= S_OUT;
              end
              default: begin
                state_r <= S_IDLE;
              end
            endcase
          end
        end
        S_OUT: begin
          // hold until the output register is free
          if (!out_valid_r || !out_stall) begin
            for (int i = 0; i < 4; i++) begin
              mac_r[i] <= {cv_r[2*i], cv_r[2*i+1]};
            end
            out_valid_r <= 1'b1;
            phase_r     <= 1'b0;
            len_r       <= '0;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign in_stall       = (state_r != S_IDLE);
  assign out_valid      = out_valid_r;
  assign out_mac_word_0 = mac_r[0];
  assign out_mac_word_1 = mac_r[1];
  assign out_mac_word_2 = mac_r[2];
  assign out_mac_word_3 = mac_r[3];
  assign cfg_ready      = 1'b1;

endmodule

[hw/rtl/hs_chk.sv]
`include "assert_macros.svh"

module hs_chk import hs_pkg::*; (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_stall,
  input logic                 in_last,
  input logic                 out_valid,
  input logic                 out_stall,
  input logic [63:0]          out_mac_word_0,
  input logic [63:0]          out_mac_word_3,
  input logic                 cfg_valid,
  input logic                 cfg_ready,
  input logic [CFG_IDX_W-1:0] cfg_index
);

  // a result waits while stalled
  `HS_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid, "result dropped under stall")

  // every accepted beat leaves the engine busy in the next cycle
  `HS_ASSERT_NEXT(a_busy_after_beat, in_valid && !in_stall, in_stall, "beat not processed")

  // the mac cannot appear straight after a beat
  `HS_ASSERT_NEXT(a_no_instant_mac, in_valid && !in_stall && in_last, !$rose(out_valid),
                  "mac too early")

  // stalled result words stay put
  `HS_ASSERT_NEXT(a_mac_stable, out_valid && out_stall,
                  $stable(out_mac_word_0) && $stable(out_mac_word_3), "mac changed under stall")

  // a key write carries a known register index
  `HS_ASSERT_NOW(a_cfg_index_known, cfg_valid && cfg_ready, !$isunknown(cfg_index),
                 "key write with unknown index")

endmodule

bind hmac_sha256_engine hs_chk u_hs_chk (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_stall       (in_stall),
  .in_last        (in_last),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_mac_word_0 (out_mac_word_0),
  .out_mac_word_3 (out_mac_word_3),
  .cfg_valid      (cfg_valid),
  .cfg_ready      (cfg_ready),
  .cfg_index      (cfg_index)
);
